// ----- hw/rtl/lcvm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcvm_pkg: shared definitions for the line clipper and viewport mapper
// Register indexes, outcode bits, reset values and the controller/datapath
// command and status structures.
// ----------------------------------------------------------------------------
package lcvm_pkg;

   localparam int COORD_WIDTH_DEF    = 16;
   localparam int MAX_CLIP_STEPS_DEF = 4;
   localparam int NUM_REGS           = 8;
   localparam int CSR_DATA_WIDTH     = 32;
   localparam int CSR_ADDR_WIDTH     = 5;
   localparam int QUOT_KEEP_BITS     = 40;

   typedef enum logic [2:0] {
      REG_CLIP_LEFT   = 3'd0,
      REG_CLIP_BOTTOM = 3'd1,
      REG_CLIP_RIGHT  = 3'd2,
      REG_CLIP_TOP    = 3'd3,
      REG_VIEW_LEFT   = 3'd4,
      REG_VIEW_BOTTOM = 3'd5,
      REG_VIEW_RIGHT  = 3'd6,
      REG_VIEW_TOP    = 3'd7
   } reg_index_type;

   localparam int RST_CLIP_LEFT   = 0;
   localparam int RST_CLIP_BOTTOM = 0;
   localparam int RST_CLIP_RIGHT  = 9600;
   localparam int RST_CLIP_TOP    = 9600;
   localparam int RST_VIEW_LEFT   = 3200;
   localparam int RST_VIEW_BOTTOM = 3200;
   localparam int RST_VIEW_RIGHT  = 4800;
   localparam int RST_VIEW_TOP    = 4800;

   localparam logic [3:0] OC_TOP    = 4'd8;
   localparam logic [3:0] OC_BOTTOM = 4'd4;
   localparam logic [3:0] OC_RIGHT  = 4'd2;
   localparam logic [3:0] OC_LEFT   = 4'd1;

   typedef enum logic [1:0] {
      MAP_START_X = 2'd0,
      MAP_START_Y = 2'd1,
      MAP_END_X   = 2'd2,
      MAP_END_Y   = 2'd3
   } map_sel_type;

   typedef struct packed {
      logic        load;
      logic        clip_setup;
      logic        map_setup;
      map_sel_type map_sel;
      logic        mul;
      logic        div_step;
      logic        clip_commit;
      logic        map_commit;
      logic        publish;
      logic        pub_acc;
      logic        pub_err;
   } dp_cmd_type;

   typedef struct packed {
      logic win_err;
      logic both_in;
      logic trivial_reject;
      logic div_zero;
   } dp_status_type;

endpackage

// ----- hw/rtl/lcvm_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcvm_req_if: line segment channel
// One beat carries both endpoints of a segment.
// ----------------------------------------------------------------------------
interface lcvm_req_if #(parameter int W = 16);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] start_x;
   logic signed [W-1:0] start_y;
   logic signed [W-1:0] end_x;
   logic signed [W-1:0] end_y;
   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ----- hw/rtl/lcvm_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcvm_rsp_if: mapped line channel
// One beat carries the accept flag, mapped endpoints and window error.
// ----------------------------------------------------------------------------
interface lcvm_rsp_if #(parameter int W = 16);
   logic                valid;
   logic                ready;
   logic                accepted;
   logic signed [W-1:0] view_start_x;
   logic signed [W-1:0] view_start_y;
   logic signed [W-1:0] view_end_x;
   logic signed [W-1:0] view_end_y;
   logic                window_error;
   modport source (output valid, accepted, view_start_x, view_start_y, view_end_x,
                   view_end_y, window_error, input ready);
   modport sink   (input valid, accepted, view_start_x, view_start_y, view_end_x,
                   view_end_y, window_error, output ready);
endinterface

// ----- hw/rtl/line_clip_and_viewport_map.sv -----
`timescale 1ns / 1ps
// A window error or trivial reject goes straight to the result; each clip step and
// each of the four mappings of an accepted line runs a multiply and a bit-serial
// divide on the shared units. Throughput: one line at a time; the next beat
// is taken once the result is handed to the output register. Reset: synchronous;
// control and CSR registers take their defaults; datapath registers have none.
// ----------------------------------------------------------------------------
// line_clip_and_viewport_map: outcode line clipper with viewport mapping
// Clips a segment against the clip window and maps the survivor into the
// viewport, one beat in and one beat out per line.
// ----------------------------------------------------------------------------
module line_clip_and_viewport_map #(
   parameter int COORD_WIDTH    = lcvm_pkg::COORD_WIDTH_DEF,
   parameter int MAX_CLIP_STEPS = lcvm_pkg::MAX_CLIP_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lcvm_req_if.sink                             req,
   lcvm_rsp_if.source                           rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lcvm_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [lcvm_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [lcvm_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import lcvm_pkg::*;

   localparam int W = COORD_WIDTH;

   // Configuration register file. Writes land on the access phase; the
   // register index is the word address, so every address hits a register.
   logic signed [W-1:0] cfg_ff [NUM_REGS];
   reg_index_type       csr_idx;
   logic                csr_wr;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_idx    = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DATA_WIDTH'(cfg_ff[csr_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_CLIP_LEFT]   <= W'(RST_CLIP_LEFT);
         cfg_ff[REG_CLIP_BOTTOM] <= W'(RST_CLIP_BOTTOM);
         cfg_ff[REG_CLIP_RIGHT]  <= W'(RST_CLIP_RIGHT);
         cfg_ff[REG_CLIP_TOP]    <= W'(RST_CLIP_TOP);
         cfg_ff[REG_VIEW_LEFT]   <= W'(RST_VIEW_LEFT);
         cfg_ff[REG_VIEW_BOTTOM] <= W'(RST_VIEW_BOTTOM);
         cfg_ff[REG_VIEW_RIGHT]  <= W'(RST_VIEW_RIGHT);
         cfg_ff[REG_VIEW_TOP]    <= W'(RST_VIEW_TOP);
      end else if (csr_wr) begin
         cfg_ff[csr_idx] <= csr_pwdata[W-1:0];
      end
   end

   // The controller sequences the clip loop and the mappings; the datapath
   // holds the endpoints, the multiplier, the divider and the result beat.
   lcvm_ctrl #(
      .W         (W),
      .MAX_STEPS (MAX_CLIP_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   lcvm_dp #(
      .W (W)
   ) u_dp (
      .clock            (clock),
      .cfg              (cfg_ff),
      .in_start_x       (req.start_x),
      .in_start_y       (req.start_y),
      .in_end_x         (req.end_x),
      .in_end_y         (req.end_y),
      .cmd              (cmd),
      .status           (status),
      .out_accepted     (rsp.accepted),
      .out_view_start_x (rsp.view_start_x),
      .out_view_start_y (rsp.view_start_y),
      .out_view_end_x   (rsp.view_end_x),
      .out_view_end_y   (rsp.view_end_y),
      .out_window_error (rsp.window_error)
   );

endmodule

// ----- hw/rtl/lcvm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcvm_ctrl: sequencing state machine
// Walks the clip loop and the four viewport mappings, one shared
// multiply and divide at a time, and owns the result valid flag.
// ----------------------------------------------------------------------------
module lcvm_ctrl #(
   parameter int W         = 16,
   parameter int MAX_STEPS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lcvm_pkg::dp_cmd_type   cmd,
   input  lcvm_pkg::dp_status_type status
);
   import lcvm_pkg::*;

   localparam int PW  = 2 * W + 2;
   localparam int CW  = $clog2(PW);
   localparam int SCW = $clog2(MAX_STEPS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_CSETUP, ST_MSETUP, ST_MUL, ST_DIV,
      ST_CCOMMIT, ST_MCOMMIT, ST_FIN
   } state_type;

   state_type   state_ff;
   logic [CW-1:0]  cnt_ff;
   logic [SCW-1:0] steps_ff;
   map_sel_type msel_ff;
   logic        is_map_ff;
   logic        acc_ff;
   logic        err_ff;
   logic        rsp_valid_ff;
   logic        can_publish;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign can_publish = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd             = '0;
      cmd.map_sel     = msel_ff;
      cmd.pub_acc     = acc_ff;
      cmd.pub_err     = err_ff;
      cmd.load        = (state_ff == ST_IDLE) && req_valid;
      cmd.clip_setup  = (state_ff == ST_CSETUP);
      cmd.map_setup   = (state_ff == ST_MSETUP);
      cmd.mul         = (state_ff == ST_MUL);
      cmd.div_step    = (state_ff == ST_DIV);
      cmd.clip_commit = (state_ff == ST_CCOMMIT);
      cmd.map_commit  = (state_ff == ST_MCOMMIT);
      cmd.publish     = (state_ff == ST_FIN) && can_publish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         steps_ff     <= '0;
         msel_ff      <= MAP_START_X;
         is_map_ff    <= 1'b0;
         acc_ff       <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_FIN) && can_publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  steps_ff <= '0;
                  acc_ff   <= 1'b0;
                  err_ff   <= 1'b0;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (status.win_err) begin
                  err_ff   <= 1'b1;
                  state_ff <= ST_FIN;
               end else if (status.both_in) begin
                  acc_ff   <= 1'b1;
                  msel_ff  <= MAP_START_X;
                  state_ff <= ST_MSETUP;
               end else if (status.trivial_reject || steps_ff == SCW'(MAX_STEPS)) begin
                  state_ff <= ST_FIN;
               end else begin
                  state_ff <= ST_CSETUP;
               end
            end
            ST_CSETUP: begin
               is_map_ff <= 1'b0;
               state_ff  <= status.div_zero ? ST_FIN : ST_MUL;
            end
            ST_MSETUP: begin
               is_map_ff <= 1'b1;
               state_ff  <= ST_MUL;
            end
            ST_MUL: begin
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(PW - 1)) begin
                  state_ff <= is_map_ff ? ST_MCOMMIT : ST_CCOMMIT;
               end
            end
            ST_CCOMMIT: begin
               steps_ff <= steps_ff + 1'b1;
               state_ff <= ST_CHECK;
            end
            ST_MCOMMIT: begin
               if (msel_ff == MAP_END_Y) begin
                  state_ff <= ST_FIN;
               end else begin
                  msel_ff  <= map_sel_type'(msel_ff + 2'd1);
                  state_ff <= ST_MSETUP;
               end
            end
            ST_FIN: begin
               if (can_publish) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/lcvm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcvm_dp: clipping and mapping datapath
// Endpoint registers, outcode logic, one magnitude multiplier and a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcvm_dp #(
   parameter int W = 16
) (
   input  logic                    clock,
   input  logic signed [W-1:0]     cfg [lcvm_pkg::NUM_REGS],
   input  logic signed [W-1:0]     in_start_x,
   input  logic signed [W-1:0]     in_start_y,
   input  logic signed [W-1:0]     in_end_x,
   input  logic signed [W-1:0]     in_end_y,
   input  lcvm_pkg::dp_cmd_type    cmd,
   output lcvm_pkg::dp_status_type status,
   output logic                    out_accepted,
   output logic signed [W-1:0]     out_view_start_x,
   output logic signed [W-1:0]     out_view_start_y,
   output logic signed [W-1:0]     out_view_end_x,
   output logic signed [W-1:0]     out_view_end_y,
   output logic                    out_window_error
);
   import lcvm_pkg::*;

   localparam int PW = 2 * W + 2;
   localparam int QL = (PW > QUOT_KEEP_BITS) ? QUOT_KEEP_BITS : PW;
   localparam int SW = QL + 2;

   logic signed [W-1:0] cl, cb, cr, ct, vl, vb, vr, vt;
   logic signed [W-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [3:0]          c0, c1, co;
   logic signed [W:0]   dx, dy;
   logic                vert, use_c0;
   logic signed [W-1:0] edge_val;
   logic signed [W:0]   sa, sb, sd;
   logic signed [W-1:0] sbase;
   logic [W:0]          ma_ff, mb_ff, dm_ff;
   logic [W:0]          ma_in, mb_in, dm_in;
   logic                neg_ff, vert_ff, usec0_ff;
   logic signed [W-1:0] base_ff, fix_ff;
   logic [W:0]          rem_ff;
   logic [PW-1:0]       dq_ff;
   logic [W+1:0]        trial;
   logic                ge;
   logic signed [SW-1:0] qs, sum;
   logic signed [W-1:0] sat_val;
   logic signed [W-1:0] map_ff [4];

   function automatic logic [3:0] region(input logic signed [W-1:0] x,
                                         input logic signed [W-1:0] y,
                                         input logic signed [W-1:0] l,
                                         input logic signed [W-1:0] b,
                                         input logic signed [W-1:0] r,
                                         input logic signed [W-1:0] t);
      logic [3:0] c;
      c = '0;
      if (y > t) c = c | OC_TOP;
      else if (y < b) c = c | OC_BOTTOM;
      if (x > r) c = c | OC_RIGHT;
      else if (x < l) c = c | OC_LEFT;
      return c;
   endfunction

   function automatic logic [W:0] magn(input logic signed [W:0] v);
      return v[W] ? -v : v;
   endfunction

   assign cl = cfg[REG_CLIP_LEFT];
   assign cb = cfg[REG_CLIP_BOTTOM];
   assign cr = cfg[REG_CLIP_RIGHT];
   assign ct = cfg[REG_CLIP_TOP];
   assign vl = cfg[REG_VIEW_LEFT];
   assign vb = cfg[REG_VIEW_BOTTOM];
   assign vr = cfg[REG_VIEW_RIGHT];
   assign vt = cfg[REG_VIEW_TOP];

   assign c0     = region(x0_ff, y0_ff, cl, cb, cr, ct);
   assign c1     = region(x1_ff, y1_ff, cl, cb, cr, ct);
   assign use_c0 = (c0 != 4'd0);
   assign co     = use_c0 ? c0 : c1;
   assign vert   = ((co & (OC_TOP | OC_BOTTOM)) != 4'd0);
   assign dx     = (W+1)'(x1_ff) - (W+1)'(x0_ff);
   assign dy     = (W+1)'(y1_ff) - (W+1)'(y0_ff);

   always_comb begin
      if (vert) begin
         edge_val = ((co & OC_TOP) != 4'd0) ? ct : cb;
      end else begin
         edge_val = ((co & OC_RIGHT) != 4'd0) ? cr : cl;
      end
   end

   assign status.win_err        = (cr <= cl) || (ct <= cb);
   assign status.both_in        = ((c0 | c1) == 4'd0);
   assign status.trivial_reject = ((c0 & c1) != 4'd0);
   assign status.div_zero       = vert ? (dy == '0) : (dx == '0);

   // Operand selection for the next multiply and divide.
   always_comb begin
      if (cmd.clip_setup) begin
         if (vert) begin
            sa    = dx;
            sb    = (W+1)'(edge_val) - (W+1)'(y0_ff);
            sd    = dy;
            sbase = x0_ff;
         end else begin
            sa    = dy;
            sb    = (W+1)'(edge_val) - (W+1)'(x0_ff);
            sd    = dx;
            sbase = y0_ff;
         end
      end else begin
         case (cmd.map_sel)
            MAP_START_X: begin sa = (W+1)'(x0_ff) - (W+1)'(cl); sbase = vl; end
            MAP_START_Y: begin sa = (W+1)'(y0_ff) - (W+1)'(cb); sbase = vb; end
            MAP_END_X:   begin sa = (W+1)'(x1_ff) - (W+1)'(cl); sbase = vl; end
            MAP_END_Y:   begin sa = (W+1)'(y1_ff) - (W+1)'(cb); sbase = vb; end
            default:     begin sa = '0; sbase = '0; end
         endcase
         if (cmd.map_sel == MAP_START_X || cmd.map_sel == MAP_END_X) begin
            sb = (W+1)'(vr) - (W+1)'(vl);
            sd = (W+1)'(cr) - (W+1)'(cl);
         end else begin
            sb = (W+1)'(vt) - (W+1)'(vb);
            sd = (W+1)'(ct) - (W+1)'(cb);
         end
      end
      ma_in = magn(sa);
      mb_in = magn(sb);
      dm_in = magn(sd);
   end

   // One restoring division step: bring down the next dividend bit.
   assign trial = {rem_ff, dq_ff[PW-1]};
   assign ge    = (trial >= {1'b0, dm_ff});

   // Signed quotient added to the base coordinate, with a saturated copy for mapping.
   always_comb begin
      qs  = neg_ff ? -SW'(dq_ff[QL-1:0]) : SW'(dq_ff[QL-1:0]);
      sum = SW'(base_ff) + qs;
      if (sum > SW'(signed'({1'b0, {(W-1){1'b1}}}))) begin
         sat_val = {1'b0, {(W-1){1'b1}}};
      end else if (sum < SW'(signed'({1'b1, {(W-1){1'b0}}}))) begin
         sat_val = {1'b1, {(W-1){1'b0}}};
      end else begin
         sat_val = sum[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff <= in_start_x;
         y0_ff <= in_start_y;
         x1_ff <= in_end_x;
         y1_ff <= in_end_y;
      end
      if (cmd.clip_setup || cmd.map_setup) begin
         ma_ff    <= ma_in;
         mb_ff    <= mb_in;
         dm_ff    <= dm_in;
         neg_ff   <= sa[W] ^ sb[W] ^ sd[W];
         base_ff  <= sbase;
         fix_ff   <= edge_val;
         vert_ff  <= vert;
         usec0_ff <= use_c0;
      end
      if (cmd.mul) begin
         dq_ff  <= PW'(ma_ff) * PW'(mb_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? (W+1)'(trial - {1'b0, dm_ff}) : trial[W:0];
         dq_ff  <= {dq_ff[PW-2:0], ge};
      end
      if (cmd.clip_commit) begin
         if (usec0_ff) begin
            x0_ff <= vert_ff ? sum[W-1:0] : fix_ff;
            y0_ff <= vert_ff ? fix_ff : sum[W-1:0];
         end else begin
            x1_ff <= vert_ff ? sum[W-1:0] : fix_ff;
            y1_ff <= vert_ff ? fix_ff : sum[W-1:0];
         end
      end
      if (cmd.map_commit) begin
         map_ff[cmd.map_sel] <= sat_val;
      end
      if (cmd.publish) begin
         out_accepted     <= cmd.pub_acc;
         out_window_error <= cmd.pub_err;
         out_view_start_x <= cmd.pub_acc ? map_ff[MAP_START_X] : '0;
         out_view_start_y <= cmd.pub_acc ? map_ff[MAP_START_Y] : '0;
         out_view_end_x   <= cmd.pub_acc ? map_ff[MAP_END_X] : '0;
         out_view_end_y   <= cmd.pub_acc ? map_ff[MAP_END_Y] : '0;
      end
   end

endmodule
